// File: hw/rtl/dwp_pkg.sv
package dwp_pkg;

	localparam logic [7:0]  MAX_CHANNELS = 8'd16;
	localparam int          MAX_TRACE_SAMPLES = 4000;
	localparam int          PAIR_W = 11;
	localparam logic [PAIR_W-1:0] MAX_PAIRS = PAIR_W'(MAX_TRACE_SAMPLES / 2);

	localparam logic [11:0] ADDR_MARK   = 12'hADD;
	localparam logic [7:0]  HDR_MODULE  = 8'hFF;
	localparam logic [7:0]  HDR_CHANNEL = 8'hF0;
	localparam logic [7:0]  TRACE_MARK  = 8'h34;
	localparam logic [3:0]  HEAD_NIBBLE = 4'hA;
	localparam logic [4:0]  MPE_RESET   = 5'd1;

	typedef enum logic [1:0] {
		KIND_HIT      = 2'd0,
		KIND_SAMPLE   = 2'd1,
		KIND_BAD_HEAD = 2'd2,
		KIND_END      = 2'd3
	} kind_t;

	typedef enum logic [14:0] {
		PH_IDLE     = 15'b000000000000001,
		PH_IDLE_END = 15'b000000000000010,
		PH_HEADER   = 15'b000000000000100,
		PH_SIZE     = 15'b000000000001000,
		PH_SKIP     = 15'b000000000010000,
		PH_CH_HDR   = 15'b000000000100000,
		PH_CH_TSLO  = 15'b000000001000000,
		PH_CH_EN    = 15'b000000010000000,
		PH_CH_SPARE = 15'b000000100000000,
		PH_CH_SKIP  = 15'b000001000000000,
		PH_TR_HDR   = 15'b000010000000000,
		PH_TR_SIZE  = 15'b000100000000000,
		PH_TR_HEAD  = 15'b001000000000000,
		PH_TR_DATA  = 15'b010000000000000,
		PH_TR_TAIL  = 15'b100000000000000
	} phase_t;

	typedef struct packed {
		logic [13:0] sample_b;
		logic [13:0] sample_a;
		logic [11:0] sample_index;
		logic [22:0] energy;
		logic [15:0] time_high;
		logic [31:0] time_low;
		logic [7:0]  channel;
		logic [7:0]  board;
		kind_t       kind;
	} result_t;

endpackage

// File: hw/rtl/digitizer_readout_word_parser_core.sv
// Path: a result reaches the master side through the input register, then the
//   parse logic into the output register.
// Throughput: one word per cycle; the input register holds its word only while a
//   result waits on the master side and m_axis_tready is low.
// Reset (arst_n low, asynchronous): parser idle, parser state cleared,
//   modules_per_event and the parser's module count = 1, no result pending.
module digitizer_readout_word_parser_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [31:0]  s_axis_tdata,   // [31:0] word
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [7:0] board, [15:8] channel, [47:16] time_low, [63:48] time_high,
	// [86:64] energy, [98:87] sample_index, [112:99] sample_a,
	// [126:113] sample_b, [127] zero
	output logic [127:0] m_axis_tdata,
	output logic [1:0]   m_axis_tuser,   // [1:0] kind
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [4:0]   cfg_data        // modules_per_event
);
	import dwp_pkg::*;

	logic        in_valid_s1;
	logic [31:0] word_s1;
	logic        out_valid_s2;
	result_t     res_s2;
	logic [4:0]  mpe_q;
	logic        step;
	logic        res_valid;
	result_t     res;

	assign step          = in_valid_s1 && (!out_valid_s2 || m_axis_tready);
	assign s_axis_tready = !in_valid_s1 || step;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mpe_q <= MPE_RESET;
		end else if (cfg_valid) begin
			mpe_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			word_s1 <= s_axis_tdata;
		end
	end

	dwp_parser u_parser (
		.clk               (clk),
		.arst_n            (arst_n),
		.step              (step),
		.word              (word_s1),
		.modules_per_event (mpe_q),
		.res_valid         (res_valid),
		.res               (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (step && res_valid) begin
			out_valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tuser  = res_s2.kind;
	assign m_axis_tdata  = {1'b0, res_s2.sample_b, res_s2.sample_a, res_s2.sample_index,
		res_s2.energy, res_s2.time_high, res_s2.time_low, res_s2.channel, res_s2.board};

endmodule

// File: hw/rtl/dwp_parser.sv
module dwp_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [31:0]       word,
	input  logic [4:0]        modules_per_event,
	output logic              res_valid,
	output dwp_pkg::result_t  res
);
	import dwp_pkg::*;

	phase_t      phase_q, phase_d;
	logic [7:0]  board_q, board_d;
	logic        known_q, known_d;
	logic [7:0]  total_q, total_d;
	logic [7:0]  slot_q, slot_d;
	logic [4:0]  ml_q, ml_d;
	logic [2:0]  skip_q, skip_d;
	logic [7:0]  hchan_q, hchan_d;
	logic [31:0] htlo_q, htlo_d;
	logic [15:0] hthi_q, hthi_d;
	logic [11:0] sleft_q, sleft_d;
	logic [11:0] spos_q, spos_d;

	logic [7:0]  slot_inc;
	logic        more;
	logic [4:0]  ml_dec;
	logic        sec_end;
	phase_t      sec_phase;
	logic [7:0]  next_slot;
	logic [2:0]  skip_dec;
	logic [27:0] q4;
	logic [29:0] q2;
	logic [PAIR_W-1:0] pairs;
	logic [4:0]  ml_load;
	phase_t      ch_phase;

	assign slot_inc  = slot_q + 8'd1;
	assign more      = slot_inc < total_q;
	assign next_slot = more ? slot_inc : 8'd0;
	assign ml_dec    = ml_q - 5'd1;
	assign sec_end   = !more && (ml_dec == 5'd0);
	assign sec_phase = more ? PH_TR_HDR : (sec_end ? PH_IDLE : PH_HEADER);
	assign skip_dec  = skip_q - 3'd1;
	assign q4        = word[31:4];
	assign q2        = word[31:2];
	assign ml_load   = (modules_per_event != 5'd0) ? modules_per_event : 5'd1;
	assign ch_phase  = known_q ? PH_CH_TSLO : PH_CH_SKIP;

	always_comb begin
		if (q2 > 30'(MAX_PAIRS) + 30'd2) begin
			pairs = MAX_PAIRS;
		end else if (q2 > 30'd2) begin
			pairs = PAIR_W'(q2 - 30'd2);
		end else begin
			pairs = '0;
		end
	end

	always_comb begin
		phase_d = phase_q;
		board_d = board_q;
		known_d = known_q;
		total_d = total_q;
		slot_d  = slot_q;
		ml_d    = ml_q;
		skip_d  = skip_q;
		hchan_d = hchan_q;
		htlo_d  = htlo_q;
		hthi_d  = hthi_q;
		sleft_d = sleft_q;
		spos_d  = spos_q;
		res_valid = 1'b0;
		res       = '0;
		res.board = board_q;
		res.kind  = KIND_END;

		unique case (phase_q)
			PH_HEADER: begin
				if (word[31:24] == HDR_MODULE) begin
					board_d = word[23:16];
					known_d = 1'b1;
					phase_d = PH_SIZE;
				end else if (word[31:24] == HDR_CHANNEL && total_q != 8'd0) begin
					slot_d  = 8'd0;
					hchan_d = word[23:16];
					hthi_d  = word[15:0];
					skip_d  = 3'd3;
					phase_d = ch_phase;
				end else begin
					phase_d = PH_HEADER;
				end
			end
			PH_SIZE: begin
				if (q4 == 28'd0) begin
					total_d = 8'd0;
				end else if (q4 > 28'(MAX_CHANNELS) + 28'd1) begin
					total_d = MAX_CHANNELS;
				end else begin
					total_d = 8'(q4 - 28'd1);
				end
				if (q4 == 28'd1) begin
					ml_d = ml_dec;
				end
				skip_d  = 3'd4;
				phase_d = PH_SKIP;
			end
			PH_SKIP: begin
				skip_d = skip_dec;
				if (skip_dec == 3'd0) begin
					if (ml_q == 5'd0) begin
						res_valid = 1'b1;
						phase_d   = PH_IDLE;
					end else begin
						phase_d = PH_HEADER;
					end
				end
			end
			PH_CH_HDR: begin
				hchan_d = word[23:16];
				hthi_d  = word[15:0];
				skip_d  = 3'd3;
				phase_d = ch_phase;
			end
			PH_CH_TSLO: begin
				htlo_d  = word;
				phase_d = PH_CH_EN;
			end
			PH_CH_EN: begin
				res_valid     = 1'b1;
				res.kind      = KIND_HIT;
				res.channel   = hchan_q;
				res.time_low  = htlo_q;
				res.time_high = hthi_q;
				res.energy    = word[23] ? 23'd0 : word[22:0];
				phase_d       = PH_CH_SPARE;
			end
			PH_CH_SPARE: begin
				slot_d  = next_slot;
				phase_d = more ? PH_CH_HDR : PH_TR_HDR;
			end
			PH_CH_SKIP: begin
				skip_d = skip_dec;
				if (skip_dec == 3'd0) begin
					slot_d  = next_slot;
					phase_d = more ? PH_CH_HDR : PH_TR_HDR;
				end
			end
			PH_TR_HDR: begin
				if (word[7:0] == TRACE_MARK) begin
					phase_d = PH_TR_SIZE;
				end else begin
					slot_d    = next_slot;
					ml_d      = more ? ml_q : ml_dec;
					phase_d   = sec_phase;
					res_valid = sec_end;
				end
			end
			PH_TR_SIZE: begin
				sleft_d = {pairs, 1'b0};
				phase_d = PH_TR_HEAD;
			end
			PH_TR_HEAD: begin
				if (word[31:28] != HEAD_NIBBLE) begin
					res_valid   = 1'b1;
					res.kind    = KIND_BAD_HEAD;
					res.channel = slot_q;
					slot_d      = next_slot;
					ml_d        = more ? ml_q : ml_dec;
					phase_d     = sec_end ? PH_IDLE_END : sec_phase;
				end else begin
					spos_d  = 12'd0;
					phase_d = (sleft_q != 12'd0) ? PH_TR_DATA : PH_TR_TAIL;
				end
			end
			PH_TR_DATA: begin
				res_valid        = 1'b1;
				res.kind         = KIND_SAMPLE;
				res.channel      = slot_q;
				res.sample_index = spos_q;
				res.sample_a     = word[13:0];
				res.sample_b     = word[29:16];
				spos_d           = spos_q + 12'd2;
				sleft_d          = (sleft_q >= 12'd2) ? sleft_q - 12'd2 : 12'd0;
				if (sleft_q <= 12'd2) begin
					phase_d = PH_TR_TAIL;
				end
			end
			PH_TR_TAIL: begin
				slot_d    = next_slot;
				ml_d      = more ? ml_q : ml_dec;
				phase_d   = sec_phase;
				res_valid = sec_end;
			end
			default: begin
				// idle, and idle after a bad head that closed the event
				res_valid = (phase_q == PH_IDLE_END);
				if (word[31:20] == ADDR_MARK) begin
					phase_d = PH_IDLE;
				end else begin
					known_d = 1'b0;
					board_d = 8'd0;
					total_d = 8'd0;
					slot_d  = 8'd0;
					ml_d    = ml_load;
					if (word[31:24] == HDR_MODULE) begin
						board_d = word[23:16];
						known_d = 1'b1;
						phase_d = PH_SIZE;
					end else begin
						phase_d = PH_HEADER;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			board_q <= '0;
			known_q <= 1'b0;
			total_q <= '0;
			slot_q  <= '0;
			ml_q    <= MPE_RESET;
			skip_q  <= '0;
			hchan_q <= '0;
			htlo_q  <= '0;
			hthi_q  <= '0;
			sleft_q <= '0;
			spos_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			board_q <= board_d;
			known_q <= known_d;
			total_q <= total_d;
			slot_q  <= slot_d;
			ml_q    <= ml_d;
			skip_q  <= skip_d;
			hchan_q <= hchan_d;
			htlo_q  <= htlo_d;
			hthi_q  <= hthi_d;
			sleft_q <= sleft_d;
			spos_q  <= spos_d;
		end
	end

endmodule

// File: hw/rtl/dwp_checker.sv
module dwp_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [127:0] m_axis_tdata,
	input logic [1:0]   m_axis_tuser
);
	import dwp_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// sample pairs and bad heads carry no hit timestamp or energy
	a_trace_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == KIND_SAMPLE || m_axis_tuser == KIND_BAD_HEAD)
		|-> m_axis_tdata[86:16] == '0)
		else $error("trace result with hit fields");

	// event end reports only the board
	a_end_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_END |-> m_axis_tdata[127:8] == '0)
		else $error("event end with stray fields");

endmodule

bind digitizer_readout_word_parser_core dwp_checker u_dwp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
